// ===== hdl/strt_pkg.sv =====
package strt_pkg;

    // Default geometry of the table.
    localparam int DEF_GRID_W    = 8;
    localparam int DEF_GRID_H    = 8;
    localparam int DEF_MAX_SLOTS = 64;

    // The final point of a path also claims its cell for this many more slots.
    localparam int HOLD_SLOTS = 5;

    // Occupied-at reports at most this many cells.
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Field widths of the channels.
    localparam int CMD_W   = 3;
    localparam int COORD_W = 3;
    localparam int TIME_W  = 8;
    localparam int ID_W    = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_RESERVE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ROBOT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PATH_POINT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_OCCUPIED_AT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL   = 3'd5;

    // One entry of the table: valid bit and owning robot.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] owner;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // One result beat.
    typedef struct packed {
        logic               flag;
        logic               found;
        logic [COORD_W-1:0] occ_x;
        logic [COORD_W-1:0] occ_y;
        logic               last;
    } t_res;

endpackage

// ===== hdl/strt_if.sv =====
// Command channel: one beat per command.
interface strt_cmd_if
    import strt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [TIME_W-1:0]  time_step;
    logic [ID_W-1:0]    robot_id;
    logic               path_last;

    modport source (
        output valid, cmd, cell_x, cell_y, time_step, robot_id, path_last,
        input  ready
    );
    modport sink (
        input  valid, cmd, cell_x, cell_y, time_step, robot_id, path_last,
        output ready
    );
endinterface

// Result channel: one or more beats per command.
interface strt_res_if
    import strt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               flag;
    logic               found;
    logic [COORD_W-1:0] occ_x;
    logic [COORD_W-1:0] occ_y;
    logic               last;

    modport source (
        output valid, flag, found, occ_x, occ_y, last,
        input  ready
    );
    modport sink (
        input  valid, flag, found, occ_x, occ_y, last,
        output ready
    );
endinterface

// ===== hdl/strt_ram.sv =====
// Single-port table memory with a registered read.
module strt_ram
    import strt_pkg::*;
#(
    parameter  int DEPTH = DEF_GRID_W * DEF_GRID_H * DEF_MAX_SLOTS,
    parameter  int DW    = SLOT_W,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write and read share one address; the read data is held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/space_time_reservation_table.sv =====
// Channel   Direction  Protocol      Beat contents
// i_cmd     in         valid/ready   cmd, cell_x, cell_y, time_step, robot_id, path_last
// o_res     out        valid/ready   flag, found, occ_x, occ_y, last
//
// After reset the table is cleared one entry a cycle, all GRID_W*GRID_H*MAX_SLOTS entries
// (4096 by default), before the first command beat is taken. Reserve and query read the slot,
// then evaluate it and answer; a path point writes its slot and answers, and a final point
// also writes up to 5 hold slots before it answers. Clear-robot reads every entry and clears
// those the robot owns, clear-all writes every entry once, occupied-at reads each scanned cell.
// One command at a time; a stalled result beat holds the sequencer only before a further beat.
module space_time_reservation_table
    import strt_pkg::*;
#(
    parameter int GRID_W    = DEF_GRID_W,
    parameter int GRID_H    = DEF_GRID_H,
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    strt_cmd_if.sink    i_cmd,
    strt_res_if.source  o_res
);

    localparam int DEPTH = GRID_W * GRID_H * MAX_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_W);
    localparam int YW    = $clog2(GRID_H);
    localparam int TTW   = 10;

    localparam logic [AW-1:0] CELLS_A = AW'(GRID_W * GRID_H);
    localparam logic [AW-1:0] ROW_A   = AW'(GRID_W);

    typedef enum logic [12:0] {
        S_INIT    = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_READ    = 13'b0000000000100,
        S_EVAL    = 13'b0000000001000,
        S_SWP_RD  = 13'b0000000010000,
        S_SWP_WR  = 13'b0000000100000,
        S_WIPE    = 13'b0000001000000,
        S_PATH    = 13'b0000010000000,
        S_HOLD    = 13'b0000100000000,
        S_OCC_RD  = 13'b0001000000000,
        S_OCC_CHK = 13'b0010000000000,
        S_OCC_END = 13'b0100000000000,
        S_RESP    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // Captured command.
    logic [CMD_W-1:0]   r_cmd;
    logic [COORD_W-1:0] r_x, r_y;
    logic [TIME_W-1:0]  r_t;
    logic [ID_W-1:0]    r_id;
    logic               r_plast;

    // Sequencer state.
    logic [AW-1:0]        r_addr, n_addr;
    logic                 r_flag, n_flag;
    logic [TTW-1:0]       r_tt, n_tt;
    logic [TTW-1:0]       r_lim, n_lim;
    logic [TIME_W-1:0]    r_path_index, n_path_index;
    logic [TIME_W-1:0]    r_path_start, n_path_start;
    logic                 r_path_over, n_path_over;
    logic [XW-1:0]        r_cx, n_cx, r_px, n_px;
    logic [YW-1:0]        r_cy, n_cy, r_py, n_py;
    logic [RES_CNT_W-1:0] r_n, n_n;
    logic                 r_pend, n_pend;

    // Result register.
    logic r_out_valid, n_out_valid;
    t_res r_out;
    logic push;
    t_res push_data;
    logic out_free;

    // Table port.
    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_addr, slot_addr;
    t_slot         ram_wr_data, rd_slot;
    logic [SLOT_W-1:0] ram_rd_raw;

    logic in_accept;
    logic cell_ok, t_ok, addr_last;
    logic path_new;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W:0]   tt_main;
    logic [TTW-1:0]    hold_end, hold_lim_raw, hold_lim;
    logic hit, cx_last, cy_last;
    logic [RES_CNT_W-1:0] n_plus;
    logic [AW-1:0] a_x, a_y, a_t;
    logic sweep_state;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_accept   = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign rd_slot   = t_slot'(ram_rd_raw);
    assign cell_ok   = (r_x < GRID_W) && (r_y < GRID_H);
    assign t_ok      = r_t < MAX_SLOTS;
    assign addr_last = (r_addr == AW'(DEPTH - 1));

    // Path timing: start time taken from the first point, hold window after the last.
    assign path_new     = (r_path_index == '0) && !r_path_over;
    assign start_eff    = path_new ? r_t : r_path_start;
    assign tt_main      = {1'b0, start_eff} + {1'b0, r_path_index};
    assign hold_end     = {1'b0, tt_main} + TTW'(1);
    assign hold_lim_raw = hold_end + TTW'(HOLD_SLOTS);
    assign hold_lim     = (hold_lim_raw > TTW'(MAX_SLOTS)) ? TTW'(MAX_SLOTS) : hold_lim_raw;

    // Occupied-at scan: column outer, row inner.
    assign hit     = rd_slot.valid && (rd_slot.owner != r_id);
    assign cx_last = (r_cx == XW'(GRID_W - 1));
    assign cy_last = (r_cy == YW'(GRID_H - 1));
    assign n_plus  = r_n + RES_CNT_W'(hit);

    // Table address of the slot the current state works on.
    always_comb begin
        a_x = AW'(r_x);
        a_y = AW'(r_y);
        a_t = AW'(r_t);
        priority if (r_state == S_OCC_RD || r_state == S_OCC_CHK) begin
            a_x = AW'(r_cx);
            a_y = AW'(r_cy);
        end else if (r_state == S_HOLD) begin
            a_t = AW'(r_tt);
        end else if (r_state == S_PATH) begin
            a_t = AW'(tt_main);
        end
    end

    assign slot_addr   = a_t * CELLS_A + a_y * ROW_A + a_x;
    assign sweep_state = (r_state == S_INIT) || (r_state == S_WIPE) ||
                         (r_state == S_SWP_RD) || (r_state == S_SWP_WR);
    assign ram_addr    = sweep_state ? r_addr : slot_addr;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_flag       = r_flag;
        n_tt         = r_tt;
        n_lim        = r_lim;
        n_path_index = r_path_index;
        n_path_start = r_path_start;
        n_path_over  = r_path_over;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_px         = r_px;
        n_py         = r_py;
        n_n          = r_n;
        n_pend       = r_pend;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_wr_data  = '{valid: 1'b0, owner: '0};
        push         = 1'b0;
        push_data    = '{flag: 1'b0, found: 1'b0, occ_x: '0, occ_y: '0, last: 1'b1};

        unique case (r_state)
            S_INIT: begin
                ram_wr_en = 1'b1;
                n_addr    = r_addr + AW'(1);
                if (addr_last) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_flag = 1'b0;
                    n_addr = '0;
                    n_cx   = '0;
                    n_cy   = '0;
                    n_n    = '0;
                    n_pend = 1'b0;
                    unique case (i_cmd.cmd)
                        CMD_RESERVE, CMD_QUERY: n_state = S_READ;
                        CMD_CLEAR_ROBOT:        n_state = S_SWP_RD;
                        CMD_PATH_POINT:         n_state = S_PATH;
                        CMD_OCCUPIED_AT:        n_state = S_OCC_RD;
                        CMD_CLEAR_ALL:          n_state = S_WIPE;
                        default:                n_state = S_RESP;
                    endcase
                end
            end
            S_READ: begin
                if (cell_ok && t_ok) begin
                    ram_rd_en = 1'b1;
                    n_state   = S_EVAL;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_EVAL: begin
                // Reserve succeeds on a free slot or one the same robot holds.
                if (r_cmd == CMD_RESERVE) begin
                    n_flag = !rd_slot.valid || (rd_slot.owner == r_id);
                    if (n_flag) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = '{valid: 1'b1, owner: r_id};
                    end
                end else begin
                    n_flag = hit;
                end
                n_state = S_RESP;
            end
            S_SWP_RD: begin
                ram_rd_en = 1'b1;
                n_state   = S_SWP_WR;
            end
            S_SWP_WR: begin
                if (rd_slot.valid && (rd_slot.owner == r_id)) begin
                    ram_wr_en = 1'b1;
                end
                n_addr  = r_addr + AW'(1);
                n_state = S_SWP_RD;
                if (addr_last) begin
                    n_addr  = '0;
                    n_state = S_RESP;
                end
            end
            S_WIPE: begin
                ram_wr_en = 1'b1;
                n_addr    = r_addr + AW'(1);
                if (addr_last) begin
                    n_addr  = '0;
                    n_state = S_RESP;
                end
            end
            S_PATH: begin
                if (!r_path_over && cell_ok && (tt_main < MAX_SLOTS)) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = '{valid: 1'b1, owner: r_id};
                end
                if (path_new) begin
                    n_path_start = r_t;
                end
                n_state = S_RESP;
                if (r_plast) begin
                    n_path_index = '0;
                    n_path_over  = 1'b0;
                    if (!r_path_over) begin
                        n_tt    = hold_end;
                        n_lim   = hold_lim;
                        n_state = S_HOLD;
                    end
                end else if (!r_path_over) begin
                    if (r_path_index == '1) begin
                        n_path_over = 1'b1;
                    end else begin
                        n_path_index = r_path_index + TIME_W'(1);
                    end
                end
            end
            S_HOLD: begin
                if (r_tt < r_lim) begin
                    ram_wr_en   = cell_ok;
                    ram_wr_data = '{valid: 1'b1, owner: r_id};
                    n_tt        = r_tt + TTW'(1);
                end else begin
                    n_state = S_RESP;
                end
            end
            S_OCC_RD: begin
                if (t_ok) begin
                    ram_rd_en = 1'b1;
                    n_state   = S_OCC_CHK;
                end else begin
                    n_state = S_OCC_END;
                end
            end
            S_OCC_CHK: begin
                // A hit is held back one step so that the final beat can carry last.
                if (!(hit && r_pend && !out_free)) begin
                    if (hit) begin
                        if (r_pend) begin
                            push      = 1'b1;
                            push_data = '{flag: 1'b0, found: 1'b1, occ_x: COORD_W'(r_px),
                                          occ_y: COORD_W'(r_py), last: 1'b0};
                        end
                        n_px   = r_cx;
                        n_py   = r_cy;
                        n_pend = 1'b1;
                        n_n    = n_plus;
                    end
                    if (cy_last) begin
                        n_cy = '0;
                        n_cx = r_cx + XW'(1);
                    end else begin
                        n_cy = r_cy + YW'(1);
                    end
                    if ((cx_last && cy_last) || (n_plus == RES_CNT_W'(MAX_RESULTS))) begin
                        n_state = S_OCC_END;
                    end else begin
                        n_state = S_OCC_RD;
                    end
                end
            end
            S_OCC_END: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_data = '{flag: 1'b0, found: r_pend,
                                  occ_x: r_pend ? COORD_W'(r_px) : '0,
                                  occ_y: r_pend ? COORD_W'(r_py) : '0, last: 1'b1};
                    n_pend    = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_data = '{flag: r_flag, found: 1'b0, occ_x: '0, occ_y: '0,
                                  last: 1'b1};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        // Result register: loaded by a push, emptied when the sink takes the beat.
        if (push) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_addr       <= '0;
            r_path_index <= '0;
            r_path_start <= '0;
            r_path_over  <= 1'b0;
            r_n          <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_path_index <= n_path_index;
            r_path_start <= n_path_start;
            r_path_over  <= n_path_over;
            r_n          <= n_n;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd   <= i_cmd.cmd;
            r_x     <= i_cmd.cell_x;
            r_y     <= i_cmd.cell_y;
            r_t     <= i_cmd.time_step;
            r_id    <= i_cmd.robot_id;
            r_plast <= i_cmd.path_last;
        end
        if (push) begin
            r_out <= push_data;
        end
        r_flag <= n_flag;
        r_tt   <= n_tt;
        r_lim  <= n_lim;
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_px   <= n_px;
        r_py   <= n_py;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.flag  = r_out.flag;
    assign o_res.found = r_out.found;
    assign o_res.occ_x = r_out.occ_x;
    assign o_res.occ_y = r_out.occ_y;
    assign o_res.last  = r_out.last;

    strt_ram #(
        .DEPTH (DEPTH),
        .DW    (SLOT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_rd_en   (ram_rd_en),
        .i_addr    (ram_addr),
        .i_wr_data (ram_wr_data),
        .o_rd_data (ram_rd_raw)
    );

    // The table is never written while a command beat can be taken.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_state != S_IDLE))
        else $error("table written while idle");

    // The final result beat of a command returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_data.last) |=> (r_state == S_IDLE))
        else $error("final beat sent without returning to idle");

    // A held-back hit is always counted.
    a_pend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_n != '0))
        else $error("pending hit not counted");

    // The occupied-at listing never exceeds its cap.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RES_CNT_W'(MAX_RESULTS))
        else $error("occupied-at count beyond cap");

    // Hold writes stay inside the time range.
    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_HOLD) && ram_wr_en) |-> (r_tt < MAX_SLOTS))
        else $error("hold write beyond time range");

endmodule

// ===== tb/tb_top.sv =====
module tb_top
    import strt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W    = DEF_GRID_W;
    localparam int GRID_H    = DEF_GRID_H;
    localparam int MAX_SLOTS = DEF_MAX_SLOTS;
    localparam int NSLOT     = GRID_W * GRID_H * MAX_SLOTS;

    // Codes the block leaves unused; they must answer with one empty beat.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // Length of the random part, counted in generated commands.
    localparam int RANDOM_ITEMS    = 346;
    localparam int LONG_PATH_PTS   = 257;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int HOLD_OFF_AFTER  = 120;
    localparam int DRAIN_CYCLES    = 50;
    localparam int WATCHDOG_LIMIT  = 40000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [TIME_W-1:0]  time_step;
        logic [ID_W-1:0]    robot_id;
        logic               path_last;
    } t_cmd_beat;

    typedef enum int {RX_FREE, RX_COIN, RX_PATTERN, RX_CHOKE} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    strt_cmd_if cmd_if ();
    strt_res_if res_if ();

    space_time_reservation_table #(
        .GRID_W   (GRID_W),
        .GRID_H   (GRID_H),
        .MAX_SLOTS(MAX_SLOTS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if)
    );

    // Shadow copy of the table and of the path tracker.
    logic            owned    [NSLOT];
    logic [ID_W-1:0] owner_id [NSLOT];
    logic [7:0]      path_len;
    logic [7:0]      path_t0;
    logic            path_overrun;

    t_cmd_beat pending_cmds [$];
    t_res      due_results  [$];

    int n_cmds_total;
    int n_cmds_taken;
    int n_res_seen;
    int n_errors;
    int n_granted;
    int n_cells_listed;
    int n_longest_list;
    int n_overruns;

    // Driver and receiver bookkeeping.
    t_cmd_beat drv_beat;
    int        burst_left;
    int        gap_left;
    t_rx_mode  rx_mode;
    int        rx_mode_left;
    int        rx_hold_left;
    bit        rx_hold_done;
    logic [1:0] rx_phase;

    // Clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit in_grid(input int unsigned x, input int unsigned y);
        return x < GRID_W && y < GRID_H;
    endfunction

    function automatic int unsigned slot_index(input int unsigned x, input int unsigned y,
                                               input int unsigned t);
        return (t * GRID_H + y) * GRID_W + x;
    endfunction

    function automatic int pick_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(0, 7);
        if (roll < 85) return $urandom_range(0, MAX_SLOTS - 1);
        return $urandom_range(0, 255);
    endfunction

    // A few robots most of the time, so that slots collide and clears hit.
    function automatic int pick_robot();
        int k;
        if ($urandom_range(0, 99) < 30) return $urandom_range(0, 255);
        k = $urandom_range(0, 3);
        return (k == 3) ? 255 : k;
    endfunction

    task automatic add_cmd(input logic [CMD_W-1:0] c, input int x, input int y,
                           input int t, input int id, input bit pl);
        t_cmd_beat b;
        b.cmd       = c;
        b.cell_x    = COORD_W'(x);
        b.cell_y    = COORD_W'(y);
        b.time_step = TIME_W'(t);
        b.robot_id  = ID_W'(id);
        b.path_last = pl;
        pending_cmds.push_back(b);
    endtask

    // Writes one slot; cells off the grid and times past the horizon are dropped.
    task automatic claim_slot(input int unsigned x, input int unsigned y,
                              input int unsigned t, input logic [ID_W-1:0] id);
        int unsigned s;
        if (in_grid(x, y) && t < MAX_SLOTS) begin
            s = slot_index(x, y, t);
            owned[s]    = 1'b1;
            owner_id[s] = id;
        end
    endtask

    // Applies one accepted command to the shadow table and queues its result beats.
    task automatic apply_table_cmd(input t_cmd_beat b);
        int unsigned s;
        int unsigned tt;
        int unsigned end_t;
        int unsigned lim;
        int          listed;
        t_res        beat;
        beat = '0;
        case (b.cmd)
            CMD_RESERVE: begin
                if (in_grid(b.cell_x, b.cell_y) && b.time_step < MAX_SLOTS) begin
                    s = slot_index(b.cell_x, b.cell_y, b.time_step);
                    if (!owned[s] || owner_id[s] == b.robot_id) begin
                        claim_slot(b.cell_x, b.cell_y, b.time_step, b.robot_id);
                        beat.flag = 1'b1;
                        n_granted++;
                    end
                end
            end
            CMD_QUERY: begin
                if (in_grid(b.cell_x, b.cell_y) && b.time_step < MAX_SLOTS) begin
                    s = slot_index(b.cell_x, b.cell_y, b.time_step);
                    beat.flag = owned[s] && owner_id[s] != b.robot_id;
                end
            end
            CMD_CLEAR_ROBOT: begin
                for (s = 0; s < NSLOT; s++)
                    if (owned[s] && owner_id[s] == b.robot_id) owned[s] = 1'b0;
            end
            CMD_PATH_POINT: begin
                // The start time is taken from the first point only.
                if (path_len == 0 && !path_overrun) path_t0 = b.time_step;
                if (!path_overrun) begin
                    tt = path_t0;
                    tt += path_len;
                    claim_slot(b.cell_x, b.cell_y, tt, b.robot_id);
                end
                if (b.path_last) begin
                    // The final cell stays held for a few more slots.
                    if (!path_overrun) begin
                        end_t = path_t0;
                        end_t += path_len + 1;
                        lim = end_t + HOLD_SLOTS;
                        if (lim > MAX_SLOTS) lim = MAX_SLOTS;
                        for (tt = end_t; tt < lim; tt++)
                            claim_slot(b.cell_x, b.cell_y, tt, b.robot_id);
                    end
                    path_len     = '0;
                    path_overrun = 1'b0;
                end else if (!path_overrun) begin
                    if (path_len == 8'd255) begin
                        path_overrun = 1'b1;
                        n_overruns++;
                    end else begin
                        path_len++;
                    end
                end
            end
            CMD_OCCUPIED_AT: begin
                // Each hit is queued once the next one is known, so the last keeps its flag.
                listed = 0;
                if (b.time_step < MAX_SLOTS) begin
                    for (int cx = 0; cx < GRID_W; cx++) begin
                        for (int cy = 0; cy < GRID_H; cy++) begin
                            s = slot_index(cx, cy, b.time_step);
                            if (listed < MAX_RESULTS && owned[s] &&
                                owner_id[s] != b.robot_id) begin
                                if (listed > 0) due_results.push_back(beat);
                                beat       = '0;
                                beat.found = 1'b1;
                                beat.occ_x = COORD_W'(cx);
                                beat.occ_y = COORD_W'(cy);
                                listed++;
                            end
                        end
                    end
                end
                n_cells_listed += listed;
                if (listed > n_longest_list) n_longest_list = listed;
            end
            CMD_CLEAR_ALL: begin
                owned = '{default: 1'b0};
            end
            default: begin
            end
        endcase
        beat.last = 1'b1;
        due_results.push_back(beat);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: result field %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            n_errors++;
        end
    endtask

    // Command driver: bursts of beats from the pending list with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            burst_left = 8;
            gap_left   = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                apply_table_cmd(drv_beat);
                n_cmds_taken++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (gap_left > 0 || pending_cmds.size() == 0) begin
                    cmd_if.valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    drv_beat = pending_cmds.pop_front();
                    cmd_if.valid     <= 1'b1;
                    cmd_if.cmd       <= drv_beat.cmd;
                    cmd_if.cell_x    <= drv_beat.cell_x;
                    cmd_if.cell_y    <= drv_beat.cell_y;
                    cmd_if.time_step <= drv_beat.time_step;
                    cmd_if.robot_id  <= drv_beat.robot_id;
                    cmd_if.path_last <= drv_beat.path_last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Result receiver: picks a random stall pattern for a random stretch and holds off
    // once for a long stretch so that the block backs up onto the command channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_mode_left = 0;
            rx_hold_left = 0;
            rx_phase     = '0;
        end else begin
            if (!rx_hold_done && n_res_seen >= HOLD_OFF_AFTER) begin
                rx_hold_left = HOLD_OFF_CYCLES;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = t_rx_mode'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(16, 96);
                end
                rx_mode_left--;
                rx_phase++;
                case (rx_mode)
                    RX_FREE:    res_if.ready <= 1'b1;
                    RX_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: res_if.ready <= (rx_phase != 2'd3);
                    default:    res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result monitor: every accepted beat is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_res_seen++;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual flag %0b",
                         $time, res_if.flag, " found %0b x %0d y %0d last %0b",
                         res_if.found, res_if.occ_x, res_if.occ_y, res_if.last);
                n_errors++;
            end else begin
                check_field("flag",  due_results[0].flag,  res_if.flag);
                check_field("found", due_results[0].found, res_if.found);
                check_field("occ_x", due_results[0].occ_x, res_if.occ_x);
                check_field("occ_y", due_results[0].occ_y, res_if.occ_y);
                check_field("last",  due_results[0].last,  res_if.last);
                void'(due_results.pop_front());
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    initial begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("%0t: no beat accepted for %0d cycles, %0d commands still to send",
                 $time, WATCHDOG_LIMIT, n_cmds_total - n_cmds_taken);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int counted;
        int pick;
        int n_pts;
        int id;
        int t0;
        bit long_done;

        i_rst_n          = 1'b0;
        owned            = '{default: 1'b0};
        owner_id         = '{default: '0};
        path_len         = '0;
        path_t0          = '0;
        path_overrun     = 1'b0;

        // Directed: ownership rules, time horizon, path hold, listing and clears.
        add_cmd(CMD_RESERVE,     0, 0,   0,   1, 0);
        add_cmd(CMD_RESERVE,     0, 0,   0,   2, 0);
        add_cmd(CMD_RESERVE,     0, 0,   0,   1, 1);
        add_cmd(CMD_QUERY,       0, 0,   0,   2, 0);
        add_cmd(CMD_QUERY,       0, 0,   0,   1, 0);
        add_cmd(CMD_RESERVE,     7, 7,  63, 255, 0);
        add_cmd(CMD_RESERVE,     7, 7,  64,   0, 0);
        add_cmd(CMD_QUERY,       7, 7, 255,   0, 0);
        add_cmd(CMD_OCCUPIED_AT, 0, 0,   0,   0, 0);
        add_cmd(CMD_OCCUPIED_AT, 0, 0, 255,   0, 0);
        // A path that runs into the end of the horizon, so the hold is cut short.
        add_cmd(CMD_PATH_POINT,  1, 1,  60,   9, 0);
        add_cmd(CMD_PATH_POINT,  2, 1,  17,   9, 0);
        add_cmd(CMD_PATH_POINT,  3, 1, 200,   9, 1);
        add_cmd(CMD_PATH_POINT,  4, 4,  10,   7, 1);
        add_cmd(CMD_PATH_POINT,  5, 5, 250, 200, 1);
        add_cmd(CMD_OCCUPIED_AT, 0, 0,  63, 255, 0);
        add_cmd(CMD_CLEAR_ROBOT, 0, 0,   0,   9, 0);
        add_cmd(CMD_OCCUPIED_AT, 7, 7,  63,   0, 1);
        add_cmd(CMD_SPARE_6,     3, 5, 129,  77, 0);
        add_cmd(CMD_SPARE_7,     7, 7, 255, 255, 1);
        add_cmd(CMD_QUERY,       4, 4,  15,   0, 0);
        add_cmd(CMD_CLEAR_ALL,   6, 2,  33,  42, 1);
        add_cmd(CMD_OCCUPIED_AT, 0, 0,  10, 255, 0);
        add_cmd(CMD_RESERVE,     3, 5,   0,   0, 0);

        // Random traffic, dense in the first few time slots.
        counted   = 0;
        long_done = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (!long_done && counted >= 150) begin
                // One path long enough to saturate the point counter; past the
                // horizon its points only move the counter.
                id = pick_robot();
                t0 = $urandom_range(0, 7);
                for (int i = 0; i < LONG_PATH_PTS; i++)
                    add_cmd(CMD_PATH_POINT, $urandom_range(0, 7), $urandom_range(0, 7),
                            (i == 0) ? t0 : $urandom_range(0, 255), id,
                            i == LONG_PATH_PTS - 1);
                add_cmd(CMD_OCCUPIED_AT, 0, 0, t0 + 3, pick_robot(), 0);
                counted  += LONG_PATH_PTS + 1;
                long_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                add_cmd(CMD_RESERVE, $urandom_range(0, 7), $urandom_range(0, 7),
                        pick_time(), pick_robot(), $urandom_range(0, 1));
                counted++;
            end else if (pick < 50) begin
                add_cmd(CMD_QUERY, $urandom_range(0, 7), $urandom_range(0, 7),
                        pick_time(), pick_robot(), $urandom_range(0, 1));
                counted++;
            end else if (pick < 70) begin
                // Short path; now and then it is left open or has a query inside it.
                n_pts = $urandom_range(1, 6);
                id    = pick_robot();
                t0    = pick_time();
                for (int i = 0; i < n_pts; i++) begin
                    add_cmd(CMD_PATH_POINT, $urandom_range(0, 7), $urandom_range(0, 7),
                            (i == 0) ? t0 : $urandom_range(0, 255), id,
                            (i == n_pts - 1) && ($urandom_range(0, 6) != 0));
                    if ($urandom_range(0, 9) == 0) begin
                        add_cmd(CMD_QUERY, $urandom_range(0, 7), $urandom_range(0, 7),
                                pick_time(), pick_robot(), 0);
                        counted++;
                    end
                end
                counted += n_pts;
            end else if (pick < 85) begin
                add_cmd(CMD_OCCUPIED_AT, $urandom_range(0, 7), $urandom_range(0, 7),
                        pick_time(), pick_robot(), $urandom_range(0, 1));
                counted++;
            end else if (pick < 88) begin
                add_cmd(CMD_CLEAR_ROBOT, $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(0, 255), pick_robot(), $urandom_range(0, 1));
                counted++;
            end else if (pick < 90) begin
                add_cmd(CMD_CLEAR_ALL, $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 1));
                counted++;
            end else if (pick < 93) begin
                add_cmd(($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7,
                        $urandom_range(0, 7), $urandom_range(0, 7),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 1));
                counted++;
            end else begin
                // Noise: any code with any fields.
                add_cmd(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 1));
                counted++;
            end
        end
        n_cmds_total = pending_cmds.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_cmds_taken < n_cmds_total || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (due_results.size() != 0) begin
            $display("%0t: %0d expected result beats never arrived",
                     $time, due_results.size());
            n_errors++;
        end
        $display("Run covered %0d commands and %0d result beats, %0d reservations granted.",
                 n_cmds_taken, n_res_seen, n_granted);
        $display("Listings reported %0d cells (longest %0d); %0d path(s) ran past 256 points.",
                 n_cells_listed, n_longest_list, n_overruns);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
